[hw/rtl/ttd_pkg.sv]
// ----------------------------------------------------------------------------
// ttd_pkg: shared types and constants of the timer table
// Command and result words, mode, kind and status codes, the controller
// state type and the command and status groups between control and datapath.
// ----------------------------------------------------------------------------
package ttd_pkg;

    // Field widths of the command and result words.
    localparam int MODE_W    = 3;
    localparam int HANDLE_W  = 4;
    localparam int PERIOD_W  = 16;
    localparam int HANDLER_W = 16;
    localparam int OWNER_W   = 16;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;

    // Per-timer flag word: enabled, triggered, loop and a two-bit kind.
    localparam int FLAG_W        = 5;
    localparam int FLAG_EN       = 0;
    localparam int FLAG_TRIG     = 1;
    localparam int FLAG_LOOP     = 2;
    localparam int FLAG_KIND_LSB = 3;

    // Command modes.
    localparam logic [MODE_W-1:0] MODE_CREATE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ENABLE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DISABLE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd5;

    // Timer kinds.
    localparam logic [KIND_W-1:0] KIND_NORMAL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MANUAL   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_REARMED = 2'd3;

    // One command word.
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [3:0]           slot;
        logic [PERIOD_W-1:0]  period;
        logic                 repeat_flag;
        logic [KIND_W-1:0]    timer_kind;
        logic [HANDLER_W-1:0] handler_id;
        logic [OWNER_W-1:0]   owner_id;
    } ttd_in_t;

    // One result word.
    typedef struct packed {
        logic [HANDLE_W-1:0]  handle_out;
        logic                 fired;
        logic [HANDLER_W-1:0] fired_handler;
        logic [KIND_W-1:0]    fired_kind;
        logic [STATUS_W-1:0]  status;
    } ttd_out_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SINGLE,
        ST_SCAN,
        ST_DONE
    } ttd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic do_create;
        logic set_simple;
        logic rd_slot;
        logic single_eval;
        logic scan_start;
        logic scan_step;
        logic scan_finish;
        logic out_load;
    } ttd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              table_full;
        logic              slot_known;
        logic              scan_done;
    } ttd_stat_t;

endpackage

[hw/rtl/ttd_ram.sv]
// ----------------------------------------------------------------------------
// ttd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/ttd_ctrl.sv]
// ----------------------------------------------------------------------------
// ttd_ctrl: command sequencer of the timer table
// Takes one command word at a time, steps the datapath through the create,
// single-slot or scan sequence and hands the result to the output register.
// ----------------------------------------------------------------------------
module ttd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ttd_pkg::ttd_stat_t stat,
    output ttd_pkg::ttd_cmd_t  cmd
);

    import ttd_pkg::*;

    ttd_state_t state_reg;
    ttd_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a word when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.mode)
                    MODE_CREATE:
                    begin
                        state_next = ST_DONE;
                    end
                    MODE_ENABLE, MODE_DISABLE, MODE_CHECK:
                    begin
                        state_next = stat.slot_known ? ST_SINGLE : ST_DONE;
                    end
                    MODE_TICK, MODE_DISPATCH:
                    begin
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SINGLE:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.latch = in_valid;
            end
            ST_DECODE:
            begin
                case (stat.mode)
                    MODE_CREATE:
                    begin
                        cmd.do_create  = !stat.table_full;
                        cmd.set_simple = stat.table_full;
                    end
                    MODE_ENABLE, MODE_DISABLE, MODE_CHECK:
                    begin
                        cmd.rd_slot    = stat.slot_known;
                        cmd.set_simple = !stat.slot_known;
                    end
                    MODE_TICK, MODE_DISPATCH:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    default:
                    begin
                        cmd.set_simple = 1'b1;
                    end
                endcase
            end
            ST_SINGLE:
            begin
                cmd.single_eval = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_step   = !stat.scan_done;
                cmd.scan_finish = stat.scan_done;
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A loaded word stays until the far side takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/ttd_dp.sv]
// ----------------------------------------------------------------------------
// ttd_dp: datapath of the timer table
// Time counter, fill count, timer record RAM, the scan pipeline used by tick
// and dispatch, the per-timer update logic and the result registers.
// ----------------------------------------------------------------------------
module ttd_dp #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ttd_pkg::ttd_cmd_t                 cmd,
    output ttd_pkg::ttd_stat_t                stat,
    input  ttd_pkg::ttd_in_t                  in_data,
    input  logic                              cfg_wr_en,
    input  logic [ttd_pkg::OWNER_W-1:0]       cfg_wr_data,
    output ttd_pkg::ttd_out_t                 out_data
);

    import ttd_pkg::*;

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam int CMP_W  = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;

    // Record layout: period, start time, handler, owner, flags.
    localparam int OFS_OWNER   = FLAG_W;
    localparam int OFS_HANDLER = OFS_OWNER + OWNER_W;
    localparam int OFS_START   = OFS_HANDLER + HANDLER_W;
    localparam int OFS_PERIOD  = OFS_START + TIME_WIDTH;
    localparam int REC_W       = OFS_PERIOD + PERIOD_W;

    // Control state.
    logic [TIME_WIDTH-1:0] now_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [OWNER_W-1:0]    cur_owner_reg;
    logic [CNT_W-1:0]      rd_idx_reg;
    logic                  ev_valid_reg;
    logic                  hit_reg;
    logic                  rearmed_reg;

    // Payload registers.
    ttd_in_t               cmd_reg;
    logic [SLOT_W-1:0]     ev_idx_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic [HANDLER_W-1:0]  hit_handler_reg;
    logic [KIND_W-1:0]     hit_kind_reg;
    logic [SLOT_W-1:0]     first_rearm_reg;
    ttd_out_t              res_reg;
    ttd_out_t              res_next;
    ttd_out_t              out_reg;

    // RAM ports.
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [REC_W-1:0]      ram_wdata;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [REC_W-1:0]      ram_rdata;

    // Fields of the record read back.
    logic [PERIOD_W-1:0]   rec_period;
    logic [TIME_WIDTH-1:0] rec_start;
    logic [HANDLER_W-1:0]  rec_handler;
    logic [OWNER_W-1:0]    rec_owner;
    logic                  rec_en;
    logic                  rec_trig;
    logic                  rec_loop;
    logic [KIND_W-1:0]     rec_kind;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  rec_expired;

    // Fields of the record written.
    logic [PERIOD_W-1:0]   w_period;
    logic [TIME_WIDTH-1:0] w_start;
    logic [HANDLER_W-1:0]  w_handler;
    logic [OWNER_W-1:0]    w_owner;
    logic                  w_en;
    logic                  w_trig;
    logic                  w_loop;
    logic [KIND_W-1:0]     w_kind;

    logic                  is_single;
    logic                  rd_more;
    logic                  ev_active;
    logic                  sc_hit;
    logic                  sc_rearm;
    logic [KIND_W-1:0]     new_kind;

    // Timer record store.
    ttd_ram #(
        .DATA_W (REC_W),
        .DEPTH  (TIMER_SLOTS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Unpack the record and test it for expiry against the current time.
    assign rec_period  = ram_rdata[OFS_PERIOD +: PERIOD_W];
    assign rec_start   = ram_rdata[OFS_START +: TIME_WIDTH];
    assign rec_handler = ram_rdata[OFS_HANDLER +: HANDLER_W];
    assign rec_owner   = ram_rdata[OFS_OWNER +: OWNER_W];
    assign rec_en      = ram_rdata[FLAG_EN];
    assign rec_trig    = ram_rdata[FLAG_TRIG];
    assign rec_loop    = ram_rdata[FLAG_LOOP];
    assign rec_kind    = ram_rdata[FLAG_KIND_LSB +: KIND_W];
    assign elapsed     = now_reg - rec_start;
    assign rec_expired = CMP_W'(elapsed) > CMP_W'(rec_period);

    // Status toward the controller.
    assign is_single       = cmd_reg.mode inside {MODE_ENABLE, MODE_DISABLE, MODE_CHECK};
    assign rd_more         = rd_idx_reg < count_reg;
    assign ev_active       = cmd.scan_step && ev_valid_reg && !hit_reg;
    assign stat.mode       = cmd_reg.mode;
    assign stat.table_full = (count_reg == CNT_W'(TIMER_SLOTS));
    assign stat.slot_known = (32'(cmd_reg.slot) < 32'(count_reg))
                             && (32'(cmd_reg.slot) < TIMER_SLOTS);
    assign stat.scan_done  = hit_reg || (!ev_valid_reg && !rd_more);

    // A kind code beyond manual is stored as normal.
    assign new_kind = (cmd_reg.timer_kind == KIND_INTERNAL
                       || cmd_reg.timer_kind == KIND_MANUAL)
                      ? cmd_reg.timer_kind : KIND_NORMAL;

    // Read address: the addressed slot, or the scan position.
    assign ram_re    = cmd.rd_slot || (cmd.scan_step && rd_more && !hit_reg);
    assign ram_raddr = cmd.rd_slot ? SLOT_W'(cmd_reg.slot) : rd_idx_reg[SLOT_W-1:0];

    // Record update for create, single-slot commands and the scan.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ev_idx_reg;
        w_period  = rec_period;
        w_start   = rec_start;
        w_handler = rec_handler;
        w_owner   = rec_owner;
        w_en      = rec_en;
        w_trig    = rec_trig;
        w_loop    = rec_loop;
        w_kind    = rec_kind;
        sc_hit    = 1'b0;
        sc_rearm  = 1'b0;
        if (cmd.do_create)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[SLOT_W-1:0];
            w_period  = cmd_reg.period;
            w_start   = now_reg;
            w_handler = cmd_reg.handler_id;
            w_owner   = cmd_reg.owner_id;
            w_en      = 1'b1;
            w_trig    = 1'b0;
            w_loop    = (new_kind == KIND_NORMAL) && cmd_reg.repeat_flag;
            w_kind    = new_kind;
        end
        else if (cmd.single_eval)
        begin
            ram_waddr = SLOT_W'(cmd_reg.slot);
            case (cmd_reg.mode)
                MODE_ENABLE:
                begin
                    ram_we  = 1'b1;
                    w_en    = 1'b1;
                    w_trig  = 1'b0;
                    w_start = now_reg;
                end
                MODE_DISABLE:
                begin
                    ram_we = 1'b1;
                    w_en   = 1'b0;
                end
                MODE_CHECK:
                begin
                    if (rec_en && rec_expired)
                    begin
                        ram_we  = 1'b1;
                        w_start = now_reg;
                    end
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
        else if (ev_active)
        begin
            if (cmd_reg.mode == MODE_TICK)
            begin
                // Mark enabled automatic timers that have run out.
                if (rec_en && rec_kind != KIND_MANUAL && rec_expired)
                begin
                    ram_we = 1'b1;
                    w_trig = 1'b1;
                end
            end
            else if (rec_en && rec_kind != KIND_MANUAL && rec_trig)
            begin
                ram_we = 1'b1;
                if (rec_kind == KIND_NORMAL && rec_owner != '0
                    && rec_owner != cur_owner_reg)
                begin
                    // Foreign owner: restart without firing.
                    sc_rearm = 1'b1;
                    w_trig   = 1'b0;
                    w_start  = now_reg;
                end
                else
                begin
                    sc_hit = 1'b1;
                    w_trig = 1'b0;
                    if (rec_kind == KIND_NORMAL && rec_loop)
                    begin
                        w_start = now_reg;
                    end
                    else
                    begin
                        w_en = 1'b0;
                    end
                end
            end
        end
    end

    assign ram_wdata = {w_period, w_start, w_handler, w_owner, w_kind, w_loop, w_trig, w_en};

    // Result of the current command.
    always_comb
    begin
        res_next = res_reg;
        if (cmd.set_simple)
        begin
            res_next = '0;
            if (cmd_reg.mode == MODE_CREATE)
            begin
                res_next.status = STAT_FULL;
            end
            else if (is_single)
            begin
                res_next.handle_out = cmd_reg.slot;
                res_next.status     = STAT_UNKNOWN;
            end
        end
        else if (cmd.do_create)
        begin
            res_next            = '0;
            res_next.handle_out = HANDLE_W'(count_reg);
        end
        else if (cmd.single_eval)
        begin
            res_next            = '0;
            res_next.handle_out = cmd_reg.slot;
            if (cmd_reg.mode == MODE_CHECK && rec_en && rec_expired)
            begin
                res_next.fired         = 1'b1;
                res_next.fired_handler = rec_handler;
                res_next.fired_kind    = rec_kind;
            end
        end
        else if (cmd.scan_finish)
        begin
            res_next = '0;
            if (cmd_reg.mode == MODE_DISPATCH)
            begin
                if (hit_reg)
                begin
                    res_next.handle_out    = HANDLE_W'(hit_idx_reg);
                    res_next.fired         = 1'b1;
                    res_next.fired_handler = hit_handler_reg;
                    res_next.fired_kind    = hit_kind_reg;
                end
                else if (rearmed_reg)
                begin
                    res_next.handle_out = HANDLE_W'(first_rearm_reg);
                    res_next.status     = STAT_REARMED;
                end
            end
        end
    end

    // Control registers: time, fill count, owner and scan progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            count_reg     <= '0;
            cur_owner_reg <= '0;
            rd_idx_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            rearmed_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cur_owner_reg <= cfg_wr_data;
            end
            if (cmd.do_create)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                rd_idx_reg   <= '0;
                ev_valid_reg <= 1'b0;
                hit_reg      <= 1'b0;
                rearmed_reg  <= 1'b0;
                if (cmd_reg.mode == MODE_TICK)
                begin
                    now_reg <= now_reg + 1'b1;
                end
            end
            if (cmd.scan_step)
            begin
                if (rd_more && !hit_reg)
                begin
                    rd_idx_reg   <= rd_idx_reg + 1'b1;
                    ev_valid_reg <= 1'b1;
                end
                else
                begin
                    ev_valid_reg <= 1'b0;
                end
                if (sc_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (sc_rearm)
                begin
                    rearmed_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers: command word, scan captures and result words.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= in_data;
        end
        if (cmd.scan_step && rd_more && !hit_reg)
        begin
            ev_idx_reg <= rd_idx_reg[SLOT_W-1:0];
        end
        if (sc_hit)
        begin
            hit_idx_reg     <= ev_idx_reg;
            hit_handler_reg <= rec_handler;
            hit_kind_reg    <= rec_kind;
        end
        if (sc_rearm && !rearmed_reg)
        begin
            first_rearm_reg <= ev_idx_reg;
        end
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_data = out_reg;

endmodule

[hw/rtl/timer_table_with_dispatch.sv]
// ----------------------------------------------------------------------------
// timer_table_with_dispatch: table of one-shot and periodic timers
// Command-driven timer table with tick marking and ordered dispatch.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and returns one result word for
// each. Create, a command on an unknown handle and the unused modes pass from
// decode straight to the result; enable, disable and manual check go through
// the single-slot state as well, since the addressed record is read from the
// table RAM and, where it changes, written back. Tick and dispatch walk the
// created timers one slot per cycle through the single read port of the
// record RAM; dispatch stops at the first timer it serves. A new word is
// accepted once the previous one has reached the output register, even while
// that result still waits to be taken. No clearing pass is needed after
// reset: only created slots are ever read.
// ----------------------------------------------------------------------------
module timer_table_with_dispatch #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ttd_pkg::ttd_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ttd_pkg::ttd_out_t           out_data,
    input  logic                        cfg_wr_en,
    input  logic [ttd_pkg::OWNER_W-1:0] cfg_wr_data
);

    import ttd_pkg::*;

    ttd_cmd_t  cmd;
    ttd_stat_t stat;

    // Command sequencer.
    ttd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Timer store and update logic.
    ttd_dp #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_data    (out_data)
    );

    // A create never writes into a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_create && stat.table_full))
    else $error("create issued on a full timer table");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
    else $error("result word overwritten while stalled");

    // After taking a word the block is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("second word accepted while a command is in progress");

    // The scan never steps past its end.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !stat.scan_done)
    else $error("scan stepped after it was done");

endmodule
